/* rtl/core/pcrq_pkg.sv */
package pcrq_pkg;

  localparam int QUEUE_ENTRIES = 8;
  localparam int NUM_CLIENTS   = 8;

  localparam int QIDX_W = $clog2(QUEUE_ENTRIES);
  localparam int CIDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int SLOT_W = $clog2(NUM_CLIENTS * QUEUE_ENTRIES);
  localparam int SLOTS  = NUM_CLIENTS * QUEUE_ENTRIES;

  localparam int MASK_W      = 8;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 136;

  localparam logic [15:0] BUSY_VALUE = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_ACK   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_ALLOC = 2'd1,
    RES_FULL      = 2'd2,
    RES_EMPTY     = 2'd3
  } result_t;

  typedef struct packed {
    logic [7:0]  unit;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  function_code;
  } req_word_t;

  typedef struct packed {
    logic [31:0] status_address;
    logic [31:0] variable_address;
  } addr_word_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    req_word_t         wr_req;
    addr_word_t        wr_adr;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } store_req_t;

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [CIDX_W-1:0] c,
                                                  input logic [QIDX_W-1:0] k);
    return SLOT_W'(32'(c) * QUEUE_ENTRIES + 32'(k));
  endfunction

  function automatic logic [QIDX_W-1:0] ring_next(input logic [QIDX_W-1:0] k);
    return (32'(k) == QUEUE_ENTRIES - 1) ? '0 : QIDX_W'(32'(k) + 1);
  endfunction

endpackage

/* rtl/core/per_client_request_ring_queue.sv */
// Each accepted transaction passes from the input register to the result register.
// Throughput: one transaction per cycle unless the output stalls; the single decision
// stage reads the valid bits and ring indices and writes entry memory in the same cycle.
// Reset clears the allocation mask, all valid bits, all ring indices and the
// pipeline valids; the entry memories are not cleared and need no clearing pass.
module per_client_request_ring_queue import pcrq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [MASK_W-1:0]      cfg_wdata,     // client_allocated_mask
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // client_id[2:0], function_code[10:3], quantity[26:11], start_address[42:27],
  // unit[50:43], variable_address[82:51], status_address[114:83],
  // return_status[130:115], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,      // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // result_code[1:0], pending[2], write_enable[3], write_address[35:4],
  // write_value[51:36], head_function_code[59:52], head_quantity[75:60],
  // head_start_address[91:76], head_unit[99:92], head_variable_address[131:100],
  // zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [MASK_W-1:0] mask_r;

  logic        in_valid_r;
  logic [1:0]  func_r;
  logic [2:0]  cid_r;
  req_word_t   req_word_r;
  addr_word_t  adr_word_r;
  logic [15:0] ret_status_r;

  logic [NUM_CLIENTS-1:0][QUEUE_ENTRIES-1:0] valid_r;
  logic [QIDX_W-1:0] insert_r [NUM_CLIENTS];
  logic [QIDX_W-1:0] head_r   [NUM_CLIENTS];

  logic        out_valid_r;
  logic [1:0]  res_code_r;
  logic        pending_r;
  logic        we_r;
  logic [31:0] waddr_r;
  logic [15:0] wval_r;
  logic        ack_ok_r;

  logic        advance;
  logic [CIDX_W-1:0] cid;
  logic        client_ok;
  logic [QIDX_W-1:0] ins_k;
  logic [QIDX_W-1:0] head_k;
  logic        ins_valid;
  logic        head_valid;

  result_t     res_code_nxt;
  logic        pending_nxt;
  logic        we_nxt;
  logic [31:0] waddr_nxt;
  logic [15:0] wval_nxt;
  logic        ack_ok_nxt;
  logic        do_add;
  logic        do_ack;

  store_req_t  st_req;
  req_word_t   rd_req;
  addr_word_t  rd_adr;
  req_word_t   head_req;
  logic [31:0] head_var;
  logic [31:0] out_waddr;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r                   <= in_tuser;
      cid_r                    <= in_tdata[2:0];
      req_word_r.function_code <= in_tdata[10:3];
      req_word_r.quantity      <= in_tdata[26:11];
      req_word_r.start_address <= in_tdata[42:27];
      req_word_r.unit          <= in_tdata[50:43];
      adr_word_r.variable_address <= in_tdata[82:51];
      adr_word_r.status_address   <= in_tdata[114:83];
      ret_status_r             <= in_tdata[130:115];
    end
  end

  assign cid        = CIDX_W'(cid_r);
  assign client_ok  = (32'(cid_r) < NUM_CLIENTS) && mask_r[cid_r];
  assign ins_k      = insert_r[cid];
  assign head_k     = head_r[cid];
  assign ins_valid  = valid_r[cid][ins_k];
  assign head_valid = valid_r[cid][head_k];

  always_comb begin
    res_code_nxt = RES_OK;
    pending_nxt  = 1'b0;
    we_nxt       = 1'b0;
    waddr_nxt    = '0;
    wval_nxt     = '0;
    ack_ok_nxt   = 1'b0;
    do_add       = 1'b0;
    do_ack       = 1'b0;
    case (func_t'(func_r))
      FUNC_ADD: begin
        if (!client_ok) begin
          res_code_nxt = RES_NOT_ALLOC;
        end else if (ins_valid) begin
          res_code_nxt = RES_FULL;
        end else begin
          do_add    = 1'b1;
          we_nxt    = 1'b1;
          waddr_nxt = adr_word_r.status_address;
          wval_nxt  = BUSY_VALUE;
        end
      end
      FUNC_ACK: begin
        if (!client_ok) begin
          res_code_nxt = RES_NOT_ALLOC;
        end else if (!head_valid) begin
          res_code_nxt = RES_EMPTY;
        end else begin
          do_ack     = 1'b1;
          we_nxt     = 1'b1;
          wval_nxt   = ret_status_r;
          ack_ok_nxt = 1'b1;
        end
      end
      FUNC_QUERY: begin
        if (!client_ok) begin
          res_code_nxt = RES_NOT_ALLOC;
        end else begin
          pending_nxt = head_valid;
        end
      end
      default: begin
        // unused code: all-zero result, no state change
      end
    endcase
  end

  // ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int c = 0; c < NUM_CLIENTS; c++) begin
        insert_r[c] <= '0;
        head_r[c]   <= '0;
      end
    end else if (advance) begin
      if (do_add) begin
        valid_r[cid][ins_k] <= 1'b1;
        insert_r[cid]       <= ring_next(ins_k);
      end
      if (do_ack) begin
        valid_r[cid][head_k] <= 1'b0;
        head_r[cid]          <= ring_next(head_k);
      end
    end
  end

  always_comb begin
    st_req.wr_en   = advance && do_add;
    st_req.wr_addr = slot_addr(cid, ins_k);
    st_req.wr_req  = req_word_r;
    st_req.wr_adr  = adr_word_r;
    st_req.rd_en   = advance && do_ack;
    st_req.rd_addr = slot_addr(cid, head_k);
  end

  pcrq_store u_store (
    .clk    (clk),
    .req    (st_req),
    .rd_req (rd_req),
    .rd_adr (rd_adr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_code_r <= res_code_nxt;
      pending_r  <= pending_nxt;
      we_r       <= we_nxt;
      waddr_r    <= waddr_nxt;
      wval_r     <= wval_nxt;
      ack_ok_r   <= ack_ok_nxt;
    end
  end

  assign head_req  = ack_ok_r ? rd_req : '0;
  assign head_var  = ack_ok_r ? rd_adr.variable_address : '0;
  assign out_waddr = ack_ok_r ? rd_adr.status_address : waddr_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       head_var,
                       head_req.unit,
                       head_req.start_address,
                       head_req.quantity,
                       head_req.function_code,
                       wval_r,
                       out_waddr,
                       we_r,
                       pending_r,
                       res_code_r};

endmodule

/* rtl/core/pcrq_store.sv */
module pcrq_store import pcrq_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output req_word_t  rd_req,
  output addr_word_t rd_adr
);

  req_word_t  req_mem [SLOTS];
  addr_word_t adr_mem [SLOTS];

  req_word_t  rd_req_r;
  addr_word_t rd_adr_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      req_mem[req.wr_addr] <= req.wr_req;
      adr_mem[req.wr_addr] <= req.wr_adr;
    end
  end

  // hold read data while the result stage is stalled
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_req_r <= req_mem[req.rd_addr];
      rd_adr_r <= adr_mem[req.rd_addr];
    end
  end

  assign rd_req = rd_req_r;
  assign rd_adr = rd_adr_r;

endmodule

/* dv/per_client_request_ring_queue_tb.sv */
`timescale 1ns / 1ps

module per_client_request_ring_queue_tb import pcrq_pkg::*;;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  // in_tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] return_status;
    logic [31:0] status_address;
    logic [31:0] variable_address;
    logic [7:0]  unit;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  function_code;
    logic [2:0]  client_id;
  } ring_req_t;

  // out_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] head_variable_address;
    logic [7:0]  head_unit;
    logic [15:0] head_start_address;
    logic [15:0] head_quantity;
    logic [7:0]  head_function_code;
    logic [15:0] write_value;
    logic [31:0] write_address;
    logic        write_enable;
    logic        pending;
    result_t     result_code;
  } ring_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [MASK_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predicted block state
  logic [MASK_W-1:0] alloc_mask;
  ring_req_t         ring_entry [NUM_CLIENTS][QUEUE_ENTRIES];
  logic              ring_valid [NUM_CLIENTS][QUEUE_ENTRIES];
  logic [QIDX_W-1:0] insert_ptr [NUM_CLIENTS];
  logic [QIDX_W-1:0] head_ptr   [NUM_CLIENTS];
  ring_reply_t       pending_replies [$];

  int err_count;
  int burst_left;
  bit steady_sender;
  int hold_off_cycles;
  int stall_mode;
  int stall_run;
  int quiet_cycles;

  per_client_request_ring_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [QIDX_W-1:0] ring_advance(input logic [QIDX_W-1:0] k);
    return (k == QIDX_W'(QUEUE_ENTRIES - 1)) ? '0 : k + 1'b1;
  endfunction

  function automatic ring_reply_t predict_ring_op(input logic [1:0] op, input ring_req_t r);
    ring_reply_t       y;
    int                c;
    logic [QIDX_W-1:0] k;
    y = '0;
    c = r.client_id;
    if (op == FUNC_UNUSED) return y;
    if (c >= NUM_CLIENTS || c >= MASK_W || !alloc_mask[c]) begin
      y.result_code = RES_NOT_ALLOC;
      return y;
    end
    case (op)
      FUNC_ADD: begin
        k = insert_ptr[c];
        if (ring_valid[c][k]) begin
          y.result_code = RES_FULL;
        end else begin
          ring_entry[c][k] = r;
          ring_valid[c][k] = 1'b1;
          insert_ptr[c]    = ring_advance(k);
          y.write_enable   = 1'b1;
          y.write_address  = r.status_address;
          y.write_value    = BUSY_VALUE;
        end
      end
      FUNC_ACK: begin
        k = head_ptr[c];
        if (!ring_valid[c][k]) begin
          y.result_code = RES_EMPTY;
        end else begin
          y.write_enable          = 1'b1;
          y.write_address         = ring_entry[c][k].status_address;
          y.write_value           = r.return_status;
          y.head_function_code    = ring_entry[c][k].function_code;
          y.head_quantity         = ring_entry[c][k].quantity;
          y.head_start_address    = ring_entry[c][k].start_address;
          y.head_unit             = ring_entry[c][k].unit;
          y.head_variable_address = ring_entry[c][k].variable_address;
          ring_valid[c][k] = 1'b0;
          head_ptr[c]      = ring_advance(k);
        end
      end
      default: begin
        y.pending = ring_valid[c][head_ptr[c]];
      end
    endcase
    return y;
  endfunction

  // Favor the extremes of each field
  function automatic logic [31:0] rand_field(input int w);
    logic [31:0] ones;
    ones = 32'hFFFF_FFFF >> (32 - w);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ones;
      default: return $urandom & ones;
    endcase
  endfunction

  function automatic ring_req_t make_req(input int client, input fill_t fill);
    ring_req_t r;
    r = '0;
    if (fill == FILL_ONES) begin
      r = {5'b0, {131{1'b1}}};
    end else if (fill == FILL_RANDOM) begin
      r.function_code    = 8'(rand_field(8));
      r.quantity         = 16'(rand_field(16));
      r.start_address    = 16'(rand_field(16));
      r.unit             = 8'(rand_field(8));
      r.variable_address = rand_field(32);
      r.status_address   = rand_field(32);
      r.return_status    = 16'(rand_field(16));
    end
    r.client_id = 3'(client);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40)
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic send_op(input logic [1:0] op, input ring_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(predict_ring_op(op, r));
  endtask

  // Drain all outstanding transactions, then update the mask
  task automatic write_alloc_mask(input logic [MASK_W-1:0] m);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    alloc_mask = m;
  endtask

  task automatic test_unallocated();
    write_alloc_mask(8'h00);
    send_op(FUNC_ADD, make_req(0, FILL_ONES));
    send_op(FUNC_ACK, make_req(7, FILL_RANDOM));
    send_op(FUNC_QUERY, make_req(0, FILL_ZERO));
    send_op(FUNC_UNUSED, make_req(7, FILL_ONES));
  endtask

  task automatic test_fill_and_drain();
    write_alloc_mask(8'hFF);
    send_op(FUNC_QUERY, make_req(7, FILL_RANDOM));
    send_op(FUNC_ACK, make_req(7, FILL_ONES));
    for (int i = 0; i < QUEUE_ENTRIES; i++)
      send_op(FUNC_ADD, make_req(7, fill_t'(i % 3)));
    send_op(FUNC_ADD, make_req(7, FILL_RANDOM));
    send_op(FUNC_QUERY, make_req(7, FILL_ZERO));
    send_op(FUNC_UNUSED, make_req(7, FILL_RANDOM));
    for (int i = 0; i < QUEUE_ENTRIES; i++)
      send_op(FUNC_ACK, make_req(7, fill_t'((i + 1) % 3)));
    send_op(FUNC_ACK, make_req(7, FILL_RANDOM));
  endtask

  // Concentrate traffic on two clients so rings fill and drain
  task automatic run_ring_mix(input logic [MASK_W-1:0] m, input int count,
                              input int add_pct);
    int          focus [2];
    int          c;
    int          roll;
    logic [1:0]  op;
    write_alloc_mask(m);
    foreach (focus[i]) begin
      do focus[i] = $urandom_range(0, NUM_CLIENTS - 1);
      while (m != 0 && !m[focus[i]]);
    end
    repeat (count) begin
      if ($urandom_range(0, 99) < 85)
        c = focus[$urandom_range(0, 1)];
      else
        c = $urandom_range(0, NUM_CLIENTS - 1);
      roll = $urandom_range(0, 99);
      if (roll < add_pct)   op = FUNC_ADD;
      else if (roll < 90)   op = FUNC_ACK;
      else                  op = FUNC_QUERY;
      send_op(op, make_req(c, FILL_RANDOM));
    end
  endtask

  task automatic test_random_mix();
    run_ring_mix(8'hFF, 120, 70);
    run_ring_mix(8'h01, 100, 45);
    run_ring_mix(8'h80, 100, 60);
    run_ring_mix(8'hA5, 120, 30);
    run_ring_mix(MASK_W'($urandom), 120, 50);
    run_ring_mix(8'h00, 30, 50);
    run_ring_mix(8'h5A, 100, 55);
  endtask

  // Hold off the result side while input keeps coming
  task automatic test_backpressure();
    write_alloc_mask(8'hFF);
    hold_off_cycles = 200;
    steady_sender   = 1'b1;
    repeat (60)
      send_op(logic'($urandom_range(0, 1)) ? FUNC_ADD : FUNC_ACK,
              make_req($urandom_range(0, 1), FILL_RANDOM));
    steady_sender = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_tready <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(1, 40);
      end
      stall_run--;
      case (stall_mode)
        0, 1:    out_tready <= 1'b1;
        2:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    ring_reply_t got;
    ring_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(got.result_code), 0);
      end else begin
        want = pending_replies.pop_front();
        if (got.result_code !== want.result_code)
          report_mismatch("result_code", 32'(got.result_code), 32'(want.result_code));
        if (got.pending !== want.pending)
          report_mismatch("pending", 32'(got.pending), 32'(want.pending));
        if (got.write_enable !== want.write_enable)
          report_mismatch("write_enable", 32'(got.write_enable), 32'(want.write_enable));
        if (got.write_address !== want.write_address)
          report_mismatch("write_address", got.write_address, want.write_address);
        if (got.write_value !== want.write_value)
          report_mismatch("write_value", 32'(got.write_value), 32'(want.write_value));
        if (got.head_function_code !== want.head_function_code)
          report_mismatch("head_function_code", 32'(got.head_function_code),
                          32'(want.head_function_code));
        if (got.head_quantity !== want.head_quantity)
          report_mismatch("head_quantity", 32'(got.head_quantity),
                          32'(want.head_quantity));
        if (got.head_start_address !== want.head_start_address)
          report_mismatch("head_start_address", 32'(got.head_start_address),
                          32'(want.head_start_address));
        if (got.head_unit !== want.head_unit)
          report_mismatch("head_unit", 32'(got.head_unit), 32'(want.head_unit));
        if (got.head_variable_address !== want.head_variable_address)
          report_mismatch("head_variable_address", got.head_variable_address,
                          want.head_variable_address);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    err_count       = 0;
    burst_left      = 0;
    steady_sender   = 1'b0;
    hold_off_cycles = 0;
    stall_run       = 0;
    quiet_cycles    = 0;
    alloc_mask      = '0;
    for (int c = 0; c < NUM_CLIENTS; c++) begin
      insert_ptr[c] = '0;
      head_ptr[c]   = '0;
      for (int k = 0; k < QUEUE_ENTRIES; k++) begin
        ring_valid[c][k] = 1'b0;
        ring_entry[c][k] = '0;
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unallocated();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();

    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pcrq_pkg.sv
rtl/core/pcrq_store.sv
rtl/core/per_client_request_ring_queue.sv
dv/per_client_request_ring_queue_tb.sv
